/* design/ldf_pkg.sv */
// ----------------------------------------------------------------------------
// ldf_pkg
// shared types, constants and status codes of the length/checksum deframer
// ----------------------------------------------------------------------------
package ldf_pkg;

    localparam int MAX_PAYLOAD = 32;
    localparam int CNT_W       = 6;
    localparam int ADDR_W      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam logic [3:0] HDR_BYTES = 4'd8;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TOO_SHORT = 3'd1;
    localparam logic [2:0] ST_OVERFLOW  = 3'd2;
    localparam logic [2:0] ST_LEN_ERR   = 3'd3;
    localparam logic [2:0] ST_SUM_ERR   = 3'd4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        out_last;
        logic        out_has_data;
        logic [2:0]  status;
        logic [31:0] valid_total;
        logic [31:0] invalid_total;
    } t_out;

    typedef struct packed {
        logic take;
        logic eval;
        logic rd_en;
        logic load_byte;
        logic load_single;
        logic clear;
    } t_dp_cmd;

    typedef struct packed {
        logic ok;
        logic count_zero;
        logic at_last_idx;
        logic out_free;
    } t_dp_sts;

endpackage

/* design/ldf_ram.sv */
// ----------------------------------------------------------------------------
// ldf_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module ldf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* design/ldf_datapath.sv */
// ----------------------------------------------------------------------------
// ldf_datapath
// header capture, payload buffer and sum, packet check, counters, output word
// ----------------------------------------------------------------------------
module ldf_datapath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ldf_pkg::t_dp_cmd i_cmd,
    output ldf_pkg::t_dp_sts o_sts,
    input  ldf_pkg::t_in    i_in_data,
    input  logic            i_out_stall,
    output logic            o_out_valid,
    output ldf_pkg::t_out   o_out_data
);
    import ldf_pkg::*;

    logic [3:0]        r_hdr_pos;
    logic [31:0]       r_len;
    logic [31:0]       r_hdr_sum;
    logic [31:0]       r_run_sum;
    logic [CNT_W-1:0]  r_count;
    logic              r_ovf;
    logic [ADDR_W-1:0] r_rd_idx;
    logic [2:0]        r_status;
    logic [31:0]       r_good;
    logic [31:0]       r_bad;
    logic              r_out_valid;
    t_out              r_out;

    logic              in_payload;
    logic              has_room;
    logic              wr_en;
    logic [2:0]        eval_status;
    logic              at_last;
    logic [7:0]        rd_data;

    assign in_payload = (r_hdr_pos == HDR_BYTES);
    assign has_room   = (r_count < CNT_W'(MAX_PAYLOAD));
    assign wr_en      = i_cmd.take && in_payload && has_room;
    assign at_last    = ((CNT_W'(r_rd_idx) + CNT_W'(1)) == r_count);

    always_comb begin
        priority if (r_hdr_pos != HDR_BYTES) begin
            eval_status = ST_TOO_SHORT;
        end else if (r_ovf) begin
            eval_status = ST_OVERFLOW;
        end else if (r_len != 32'(r_count)) begin
            eval_status = ST_LEN_ERR;
        end else if (r_run_sum != r_hdr_sum) begin
            eval_status = ST_SUM_ERR;
        end else begin
            eval_status = ST_OK;
        end
    end

    ldf_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PAYLOAD),
        .AW    (ADDR_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[ADDR_W-1:0]),
        .i_wr_data (i_in_data.in_byte),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (r_rd_idx),
        .o_rd_data (rd_data)
    );

    // packet state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_pos <= '0;
            r_len     <= '0;
            r_hdr_sum <= '0;
            r_run_sum <= '0;
            r_count   <= '0;
            r_ovf     <= 1'b0;
            r_rd_idx  <= '0;
            r_status  <= ST_OK;
            r_good    <= '0;
            r_bad     <= '0;
        end else if (i_cmd.clear) begin
            r_hdr_pos <= '0;
            r_len     <= '0;
            r_hdr_sum <= '0;
            r_run_sum <= '0;
            r_count   <= '0;
            r_ovf     <= 1'b0;
            r_rd_idx  <= '0;
        end else begin
            if (i_cmd.take) begin
                if (!in_payload) begin
                    if (!r_hdr_pos[2]) begin
                        r_len[8*r_hdr_pos[1:0] +: 8] <= i_in_data.in_byte;
                    end else begin
                        r_hdr_sum[8*r_hdr_pos[1:0] +: 8] <= i_in_data.in_byte;
                    end
                    r_hdr_pos <= r_hdr_pos + 4'd1;
                end else begin
                    r_run_sum <= r_run_sum + 32'(i_in_data.in_byte);
                    if (has_room) begin
                        r_count <= r_count + CNT_W'(1);
                    end else begin
                        r_ovf <= 1'b1;
                    end
                end
            end
            if (i_cmd.eval) begin
                r_status <= eval_status;
                if (eval_status == ST_OK) begin
                    r_good <= r_good + 32'd1;
                end else begin
                    r_bad <= r_bad + 32'd1;
                end
            end
            if (i_cmd.load_byte) begin
                r_rd_idx <= r_rd_idx + ADDR_W'(1);
            end
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_byte || i_cmd.load_single) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_byte) begin
            r_out.out_byte      <= rd_data;
            r_out.out_last      <= at_last;
            r_out.out_has_data  <= 1'b1;
            r_out.status        <= ST_OK;
            r_out.valid_total   <= r_good;
            r_out.invalid_total <= r_bad;
        end else if (i_cmd.load_single) begin
            r_out.out_byte      <= '0;
            r_out.out_last      <= 1'b1;
            r_out.out_has_data  <= 1'b0;
            r_out.status        <= r_status;
            r_out.valid_total   <= r_good;
            r_out.invalid_total <= r_bad;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_data       = r_out;
    assign o_sts.ok         = (eval_status == ST_OK);
    assign o_sts.count_zero = (r_count == '0);
    assign o_sts.at_last_idx = at_last;
    assign o_sts.out_free   = !r_out_valid || !i_out_stall;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load_byte || i_cmd.load_single) |-> (!r_out_valid || !i_out_stall))
        else $error("output word overwritten while stalled");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_PAYLOAD))
        else $error("payload count beyond buffer");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> (r_hdr_pos == HDR_BYTES))
        else $error("payload counted before header complete");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_single |=> (r_out_valid && r_out.out_last && !r_out.out_has_data))
        else $error("single result not marked last");

endmodule

/* design/ldf_ctrl.sv */
// ----------------------------------------------------------------------------
// ldf_ctrl
// sequencer: receive, check, buffer readout or single status word
// ----------------------------------------------------------------------------
module ldf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_last,
    output logic             o_in_stall,
    input  ldf_pkg::t_dp_sts i_sts,
    output ldf_pkg::t_dp_cmd o_cmd
);
    import ldf_pkg::*;

    localparam logic [2:0] S_RECV   = 3'd0;
    localparam logic [2:0] S_EVAL   = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_LOAD   = 3'd3;
    localparam logic [2:0] S_SINGLE = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_RECV: begin
                o_cmd.take = i_in_valid;
                if (i_in_valid && i_in_last) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                if (i_sts.ok && !i_sts.count_zero) begin
                    n_state = S_READ;
                end else begin
                    n_state = S_SINGLE;
                end
            end
            S_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_LOAD;
            end
            S_LOAD: begin
                if (i_sts.out_free) begin
                    o_cmd.load_byte = 1'b1;
                    if (i_sts.at_last_idx) begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_RECV;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_SINGLE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_single = 1'b1;
                    o_cmd.clear       = 1'b1;
                    n_state           = S_RECV;
                end
            end
            default: begin
                n_state = S_RECV;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RECV;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_RECV);

endmodule

/* design/length_checksum_deframer.sv */
// ----------------------------------------------------------------------------
// length_checksum_deframer
// length-prefixed packet deframer with byte-sum check and packet counters
// ----------------------------------------------------------------------------
// Each header or payload byte is taken while the block receives. After the
// word flagged last, the packet is evaluated; a rejected or empty packet then
// gives one status word, and an accepted packet is read back from the payload
// ram byte by byte, each byte through a registered ram read and then a load
// of the output register, which waits while the output is stalled. No input
// word is taken during evaluation, readout or the status word.
module length_checksum_deframer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  ldf_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output ldf_pkg::t_out o_out_data
);
    import ldf_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    ldf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_last  (i_in_data.in_last),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ldf_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
